@@ sv/column_reverse_max_pool_backward_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the column reverse max-pool backward block
// Each macro expects clk and rst_n in the scope of the module that uses it.
// ----------------------------------------------------------------------------
`ifndef COLUMN_REVERSE_MAX_POOL_BACKWARD_ASSERT_SVH
`define COLUMN_REVERSE_MAX_POOL_BACKWARD_ASSERT_SVH

// Condition holds at every edge out of reset.
`define CRMP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define CRMP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CRMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/crmp_pkg.sv @@
// ----------------------------------------------------------------------------
// crmp_pkg
// Shared constants and types of the column reverse max-pool backward block.
// ----------------------------------------------------------------------------
package crmp_pkg;

    // Command carried in tuser
    typedef enum logic [0:0] {
        CMD_LOAD  = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_e;

    // Configuration register indexes
    localparam logic [7:0] REG_WIDTH  = 8'd0;
    localparam logic [7:0] REG_HEIGHT = 8'd1;

    localparam int DATA_W = 16;
    localparam int ACC_W  = 24;
    localparam int CFG_W  = 8;

    localparam logic signed [ACC_W:0] ACC_MAX = 25'sd8388607;
    localparam logic signed [ACC_W:0] ACC_MIN = -25'sd8388608;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

endpackage

@@ sv/crmp_front.sv @@
// ----------------------------------------------------------------------------
// crmp_front
// Accepts load and drain commands, holds the plane size registers and the
// load and drain position counters, and queues resolved commands for the back.
// ----------------------------------------------------------------------------
module crmp_front #(
    parameter int  MAX_WIDTH  = 128,
    parameter int  MAX_HEIGHT = 128,
    parameter type entry_t    = logic
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [crmp_pkg::CFG_W-1:0]      cfg_index,
    input  logic [crmp_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  crmp_pkg::cmd_e                  in_cmd,
    input  logic signed [crmp_pkg::DATA_W-1:0] in_act,
    input  logic signed [crmp_pkg::DATA_W-1:0] in_grad,
    input  logic                            clearing,
    input  logic                            q_full,
    output logic                            q_push,
    output entry_t                          q_entry
);

    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int W_RST_LAST = (128 > MAX_WIDTH) ? MAX_WIDTH - 1 : 127;
    localparam int H_RST_LAST = (128 > MAX_HEIGHT) ? MAX_HEIGHT - 1 : 127;

    logic [CW-1:0] w_last_reg, w_last_next;
    logic [RW-1:0] h_last_reg, h_last_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic          plane_full_reg, plane_full_next;
    logic [RW-1:0] drain_row_reg, drain_row_next;
    logic [CW-1:0] drain_col_reg, drain_col_next;

    logic          cfg_wr;
    logic          accept;
    logic [CW-1:0] w_clamp;
    logic [RW-1:0] h_clamp;
    logic          drain_last;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    // Hold off command transfers while a register write is offered
    assign in_ready  = !q_full && !clearing && !cfg_valid;
    assign accept    = in_valid && in_ready;

    // Size register to last index: zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (cfg_data == '0)
        begin
            w_clamp = '0;
            h_clamp = '0;
        end
        else
        begin
            if (32'(cfg_data) > 32'(MAX_WIDTH))
                w_clamp = CW'(MAX_WIDTH - 1);
            else
                w_clamp = CW'(cfg_data - 8'd1);
            if (32'(cfg_data) > 32'(MAX_HEIGHT))
                h_clamp = RW'(MAX_HEIGHT - 1);
            else
                h_clamp = RW'(cfg_data - 8'd1);
        end
    end

    assign drain_last = (drain_row_reg == h_last_reg) && (drain_col_reg == w_last_reg);

    always_comb
    begin
        w_last_next     = w_last_reg;
        h_last_next     = h_last_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        plane_full_next = plane_full_reg;
        drain_row_next  = drain_row_reg;
        drain_col_next  = drain_col_reg;
        q_push          = 1'b0;

        q_entry           = '0;
        q_entry.act       = in_act;
        q_entry.grad      = in_grad;
        q_entry.drain     = (in_cmd == crmp_pkg::CMD_DRAIN);
        q_entry.first_row = (row_reg == '0);
        q_entry.last      = drain_last;
        if (in_cmd == crmp_pkg::CMD_DRAIN)
        begin
            q_entry.row = drain_row_reg;
            q_entry.col = drain_col_reg;
        end
        else
        begin
            q_entry.row = h_last_reg - row_reg;
            q_entry.col = col_reg;
        end

        if (cfg_wr)
        begin
            if (cfg_index == crmp_pkg::REG_WIDTH || cfg_index == crmp_pkg::REG_HEIGHT)
            begin
                if (cfg_index == crmp_pkg::REG_WIDTH)
                    w_last_next = w_clamp;
                else
                    h_last_next = h_clamp;
                row_next        = '0;
                col_next        = '0;
                plane_full_next = 1'b0;
                drain_row_next  = '0;
                drain_col_next  = '0;
            end
        end
        else if (accept)
        begin
            if (in_cmd == crmp_pkg::CMD_DRAIN)
            begin
                q_push = 1'b1;
                if (drain_last)
                begin
                    row_next        = '0;
                    col_next        = '0;
                    plane_full_next = 1'b0;
                    drain_row_next  = '0;
                    drain_col_next  = '0;
                end
                else if (drain_col_reg == w_last_reg)
                begin
                    drain_col_next = '0;
                    drain_row_next = drain_row_reg + 1'b1;
                end
                else
                begin
                    drain_col_next = drain_col_reg + 1'b1;
                end
            end
            else if (!plane_full_reg)
            begin
                // Drop loads once the plane is complete
                q_push = 1'b1;
                if (col_reg == w_last_reg)
                begin
                    col_next = '0;
                    if (row_reg == h_last_reg)
                    begin
                        row_next        = '0;
                        plane_full_next = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg     <= CW'(W_RST_LAST);
            h_last_reg     <= RW'(H_RST_LAST);
            row_reg        <= '0;
            col_reg        <= '0;
            plane_full_reg <= 1'b0;
            drain_row_reg  <= '0;
            drain_col_reg  <= '0;
        end
        else
        begin
            w_last_reg     <= w_last_next;
            h_last_reg     <= h_last_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            plane_full_reg <= plane_full_next;
            drain_row_reg  <= drain_row_next;
            drain_col_reg  <= drain_col_next;
        end
    end

endmodule

@@ sv/crmp_queue.sv @@
// ----------------------------------------------------------------------------
// crmp_queue
// Short first-in first-out command queue between front and back.
// ----------------------------------------------------------------------------
module crmp_queue #(
    parameter type entry_t = logic
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t pop_entry,
    output logic   empty
);

    localparam int PW = crmp_pkg::QUEUE_PTR_W;

    entry_t        slots [crmp_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;

    assign full      = (count_reg == (PW+1)'(crmp_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/crmp_back.sv @@
// ----------------------------------------------------------------------------
// crmp_back
// Runs queued commands against the column state and accumulator memories:
// compare-and-update for loads, read-and-clear for drains.
// ----------------------------------------------------------------------------
`include "column_reverse_max_pool_backward_assert.svh"

module crmp_back #(
    parameter int  MAX_WIDTH  = 128,
    parameter int  MAX_HEIGHT = 128,
    parameter type entry_t    = logic
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  entry_t                            q_entry,
    output logic                              q_pop,
    output logic                              clearing,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [crmp_pkg::ACC_W-1:0]        out_grad,
    output logic                              out_last
);

    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int AW    = RW + CW;
    localparam int ACC_W = crmp_pkg::ACC_W;
    localparam int DW    = crmp_pkg::DATA_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_ADD
    } state_t;

    // Memories
    logic signed [DW-1:0]    col_max_mem [MAX_WIDTH];
    logic [RW-1:0]           col_arg_mem [MAX_WIDTH];
    logic signed [ACC_W-1:0] acc_mem     [2**AW];

    logic signed [DW-1:0]    col_max_rd_reg;
    logic [RW-1:0]           col_arg_rd_reg;
    logic signed [ACC_W-1:0] acc_rd_reg;

    // FSM registers
    state_t                  state_reg, state_next;
    entry_t                  cur_reg, cur_next;
    logic [RW-1:0]           arg_row_reg, arg_row_next;
    logic [AW-1:0]           clr_addr_reg, clr_addr_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ACC_W-1:0]        out_grad_reg, out_grad_next;
    logic                    out_last_reg, out_last_next;

    // Memory port controls
    logic                    col_re, col_we;
    logic [CW-1:0]           col_rd_addr;
    logic                    acc_re, acc_we;
    logic [AW-1:0]           acc_rd_addr, acc_wr_addr;
    logic signed [ACC_W-1:0] acc_wr_data;

    logic                    take;
    logic [RW-1:0]           arg_row;
    logic signed [ACC_W:0]   sum;
    logic                    out_free;

    assign clearing  = (state_reg == S_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_grad  = out_grad_reg;
    assign out_last  = out_last_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign take    = cur_reg.first_row || (cur_reg.act > col_max_rd_reg);
    assign arg_row = take ? cur_reg.row : col_arg_rd_reg;
    assign sum     = (ACC_W+1)'(acc_rd_reg) + (ACC_W+1)'(cur_reg.grad);

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        arg_row_next   = arg_row_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_grad_next  = out_grad_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        col_re         = 1'b0;
        col_we         = 1'b0;
        col_rd_addr    = q_entry.col;
        acc_re         = 1'b0;
        acc_we         = 1'b0;
        acc_rd_addr    = {q_entry.row, q_entry.col};
        acc_wr_addr    = {cur_reg.row, cur_reg.col};
        acc_wr_data    = '0;

        case (state_reg)
            S_CLEAR:
            begin
                acc_we      = 1'b1;
                acc_wr_addr = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_entry;
                    col_re     = !q_entry.drain;
                    acc_re     = q_entry.drain;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (cur_reg.drain)
                begin
                    // Hold until the output register frees up
                    if (out_free)
                    begin
                        acc_we         = 1'b1;
                        out_valid_next = 1'b1;
                        out_grad_next  = acc_rd_reg;
                        out_last_next  = cur_reg.last;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    col_we       = take;
                    acc_re       = 1'b1;
                    acc_rd_addr  = {arg_row, cur_reg.col};
                    arg_row_next = arg_row;
                    state_next   = S_ADD;
                end
            end
            S_ADD:
            begin
                acc_we      = 1'b1;
                acc_wr_addr = {arg_row_reg, cur_reg.col};
                if (sum > crmp_pkg::ACC_MAX)
                    acc_wr_data = ACC_W'(crmp_pkg::ACC_MAX);
                else if (sum < crmp_pkg::ACC_MIN)
                    acc_wr_data = ACC_W'(crmp_pkg::ACC_MIN);
                else
                    acc_wr_data = ACC_W'(sum);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (col_re)
        begin
            col_max_rd_reg <= col_max_mem[col_rd_addr];
            col_arg_rd_reg <= col_arg_mem[col_rd_addr];
        end
        if (col_we)
        begin
            col_max_mem[cur_reg.col] <= cur_reg.act;
            col_arg_mem[cur_reg.col] <= cur_reg.row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_re)
            acc_rd_reg <= acc_mem[acc_rd_addr];
        if (acc_we)
            acc_mem[acc_wr_addr] <= acc_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cur_reg       <= '0;
            arg_row_reg   <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_grad_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            arg_row_reg   <= arg_row_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            out_grad_reg  <= out_grad_next;
            out_last_reg  <= out_last_next;
        end
    end

    `CRMP_ASSERT_ALWAYS(a_acc_port_exclusive, !(acc_re && acc_we), "accumulator read and write in one cycle")
    `CRMP_ASSERT_IMPLY(a_no_result_while_clearing, state_reg == S_CLEAR, !out_valid_reg, "result during clearing pass")
    `CRMP_ASSERT_NEXT(a_load_goes_to_add, state_reg == S_LOOK && !cur_reg.drain, state_reg == S_ADD, "load skipped accumulate step")
    `CRMP_ASSERT_IMPLY(a_col_write_on_load, col_we, state_reg == S_LOOK && !cur_reg.drain, "column state written outside load compare")

endmodule

@@ sv/column_reverse_max_pool_backward.sv @@
// ----------------------------------------------------------------------------
// column_reverse_max_pool_backward
// Gradient of a column-wise reverse running maximum (top pooling), one plane
// at a time, Q8.8 inputs and saturating 24-bit Q16.8 accumulators.
// ----------------------------------------------------------------------------
// Usage: after reset the accumulator memory is swept to zero, one entry per
// cycle, over 2**(clog2(MAX_HEIGHT)+clog2(MAX_WIDTH)) entries (16384 at the
// defaults); s_tready stays low during that pass. Send the plane's samples
// (tuser = load) from the bottom row up, left to right, then issue one drain
// (tuser = drain) per entry; drains come back in row-major order from the top
// row and m_tlast marks the plane's final entry. Each command is accepted into
// a four-entry queue at up to one per cycle while s_tready is high; the back
// end finishes each command before it pops the next, in a read-modify-write
// sequence on the single accumulator memory: a load takes a column read, a
// compare plus accumulator read and an accumulate write, and a drain takes an
// accumulator read and then a clear plus result. Loads that arrive after the
// plane is complete are dropped. Write the size registers only while the
// block is idle; each write restarts the position counters.
// ----------------------------------------------------------------------------
module column_reverse_max_pool_backward #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // Command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] activation, [31:16] gradient
    input  logic [0:0]  s_tuser,    // [0] cmd
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [23:0] grad_value
    output logic        m_tlast
);

    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // Resolved command handed from front to back
    typedef struct packed {
        logic                                drain;
        logic                                first_row;
        logic [RW-1:0]                       row;
        logic [CW-1:0]                       col;
        logic                                last;
        logic signed [crmp_pkg::DATA_W-1:0]  act;
        logic signed [crmp_pkg::DATA_W-1:0]  grad;
    } entry_t;

    entry_t push_entry;
    entry_t pop_entry;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    logic   clearing;

    // Front: classify, track plane position, drop loads past the plane
    crmp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .entry_t    (entry_t)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (crmp_pkg::cmd_e'(s_tuser[0])),
        .in_act    (s_tdata[15:0]),
        .in_grad   (s_tdata[31:16]),
        .clearing  (clearing),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    // Queue decouples acceptance from memory work
    crmp_queue #(
        .entry_t (entry_t)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    // Back: column compare, accumulate, drain and clear
    crmp_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .entry_t    (entry_t)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_entry   (pop_entry),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_grad  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
